/* hdl/crdf_pkg.sv */
package crdf_pkg;

    // Counter and field widths
    localparam int CNT_W   = 29;
    localparam int SCORE_W = 32;

    // Longest chain that is still counted
    localparam logic [CNT_W-1:0] MAX_CHAIN_PAIRS = 29'h1000_0000;

    // Operand split for the shared multiplier
    localparam int CHUNK_W = 18;
    localparam int OP_W    = 2 * CHUNK_W;
    localparam int PROD_W  = SCORE_W + CHUNK_W + 1;
    localparam int ACC_W   = SCORE_W + OP_W + 1;

    // Stream widths
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 64;

    // ASCII codes of the nucleotide letters
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_C_UP = 8'h43;
    localparam logic [7:0] CH_G_UP = 8'h47;
    localparam logic [7:0] CH_T_UP = 8'h54;
    localparam logic [7:0] CH_U_UP = 8'h55;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_C_LO = 8'h63;
    localparam logic [7:0] CH_G_LO = 8'h67;
    localparam logic [7:0] CH_N_LO = 8'h6e;
    localparam logic [7:0] CH_T_LO = 8'h74;
    localparam logic [7:0] CH_U_LO = 8'h75;

    // Nucleotide class codes
    localparam logic [1:0] CLASS_A = 2'd0;
    localparam logic [1:0] CLASS_C = 2'd1;
    localparam logic [1:0] CLASS_G = 2'd2;
    localparam logic [1:0] CLASS_T = 2'd3;

    // Per-chain totals handed from the counting side to the decision side
    typedef struct packed {
        logic [3:0][CNT_W-1:0]      match;
        logic [CNT_W-1:0]           repeats;
        logic [CNT_W-1:0]           pairs;
        logic                       ovf;
        logic signed [SCORE_W-1:0]  score;
    } summary_t;

    // Class of a byte: bit 2 set when it is one of ACGTU in either case
    function automatic logic [2:0] base_class(input logic [7:0] c);
        logic [2:0] r;
        case (c) inside
            CH_A_UP, CH_A_LO:                   r = {1'b1, CLASS_A};
            CH_C_UP, CH_C_LO:                   r = {1'b1, CLASS_C};
            CH_G_UP, CH_G_LO:                   r = {1'b1, CLASS_G};
            CH_T_UP, CH_T_LO, CH_U_UP, CH_U_LO: r = {1'b1, CLASS_T};
            default:                            r = 3'b000;
        endcase
        return r;
    endfunction

    // Lowercase a, c, g, t or n marks a repeat-masked base
    function automatic logic is_repeat_base(input logic [7:0] c);
        return (c == CH_A_LO) || (c == CH_C_LO) || (c == CH_G_LO) ||
               (c == CH_T_LO) || (c == CH_N_LO);
    endfunction

endpackage

/* hdl/crdf_front.sv */
module crdf_front import crdf_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,
    output summary_t            sum_data,
    output logic                sum_valid,
    input  logic                sum_ready
);

    logic [3:0][CNT_W-1:0] match_reg, match_next, match_upd;
    logic [CNT_W-1:0]      repeat_reg, repeat_next, repeat_upd;
    logic [CNT_W-1:0]      pair_reg, pair_next, pair_upd;
    logic                  ovf_reg, ovf_next, ovf_upd;

    logic                  accept;
    logic                  full;
    logic                  hit;
    logic                  rep;
    logic [2:0]            tc;
    logic [2:0]            qc;

    // Stall only when the queue has no room
    assign s_tready = sum_ready;
    assign accept   = s_tvalid && s_tready;

    // Classify the pair
    assign tc   = base_class(s_tdata[7:0]);
    assign qc   = base_class(s_tdata[15:8]);
    assign hit  = qc[2] && (qc == tc);
    assign rep  = is_repeat_base(s_tdata[15:8]) || is_repeat_base(s_tdata[7:0]);
    assign full = pair_reg >= MAX_CHAIN_PAIRS;

    // Count the pair, or flag overflow once the bound is reached
    always_comb begin
        match_upd  = match_reg;
        repeat_upd = repeat_reg;
        pair_upd   = pair_reg;
        ovf_upd    = ovf_reg;
        if (full) begin
            ovf_upd = 1'b1;
        end else begin
            pair_upd = pair_reg + 1'b1;
            if (hit) begin
                match_upd[qc[1:0]] = match_reg[qc[1:0]] + 1'b1;
            end
            if (rep) begin
                repeat_upd = repeat_reg + 1'b1;
            end
        end
    end

    // Clear after the last pair of a chain
    always_comb begin
        match_next  = match_reg;
        repeat_next = repeat_reg;
        pair_next   = pair_reg;
        ovf_next    = ovf_reg;
        if (accept) begin
            if (s_tlast) begin
                match_next  = '0;
                repeat_next = '0;
                pair_next   = '0;
                ovf_next    = 1'b0;
            end else begin
                match_next  = match_upd;
                repeat_next = repeat_upd;
                pair_next   = pair_upd;
                ovf_next    = ovf_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg  <= '0;
            repeat_reg <= '0;
            pair_reg   <= '0;
            ovf_reg    <= 1'b0;
        end else begin
            match_reg  <= match_next;
            repeat_reg <= repeat_next;
            pair_reg   <= pair_next;
            ovf_reg    <= ovf_next;
        end
    end

    // Push the chain totals on the last pair
    assign sum_valid        = accept && s_tlast;
    assign sum_data.match   = match_upd;
    assign sum_data.repeats = repeat_upd;
    assign sum_data.pairs   = pair_upd;
    assign sum_data.ovf     = ovf_upd;
    assign sum_data.score   = s_tdata[47:16];

endmodule

/* hdl/crdf_queue.sv */
module crdf_queue import crdf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  summary_t in_data,
    input  logic     in_valid,
    output logic     in_ready,
    output summary_t out_data,
    output logic     out_valid,
    input  logic     out_ready
);

    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    summary_t   mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign in_ready  = count_reg != QUEUE_DEPTH;
    assign out_valid = count_reg != 2'd0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

/* hdl/crdf_back.sv */
module crdf_back import crdf_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  summary_t                   sum_data,
    input  logic                       sum_valid,
    output logic                       sum_ready,
    input  logic signed [SCORE_W-1:0]  min_score,
    input  logic signed [SCORE_W-1:0]  no_check_score,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [M_DATA_W-1:0]        m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE, S_SUM, S_BEST, S_PREP, S_MUL, S_EVAL, S_DONE
    } state_t;

    typedef enum logic {CMP_DEGEN, CMP_REPEAT} cmp_sel_t;

    localparam logic [2:0] LAST_STEP = 3'd4;
    localparam int         EXT_W     = CNT_W + 11;

    state_t                    state_reg;
    summary_t                  sum_reg;
    logic [CNT_W-1:0]          m_reg;
    logic [5:0][CNT_W-1:0]     pair_sum_reg;
    logic [CNT_W-1:0]          best_reg;
    logic [OP_W-1:0]           op_x_reg;
    logic [OP_W-1:0]           op_y_reg;
    logic [2:0]                step_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      prod_shift_reg;
    logic                      prod_neg_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    cmp_sel_t                  cmp_sel_reg;
    logic                      pass_reg;
    logic                      out_valid_reg;
    logic [M_DATA_W-1:0]       out_data_reg;

    logic [CNT_W+1:0]          m_sum;
    logic [5:0][CNT_W-1:0]     pair_sum;
    logic [CNT_W-1:0]          best_max;
    logic [EXT_W-1:0]          m_ext;
    logic [EXT_W-1:0]          b_ext;
    logic [EXT_W-1:0]          x_degen;
    logic [EXT_W-1:0]          y_degen;
    logic                      degen_bad;
    logic [CNT_W-1:0]          unmasked;
    logic [OP_W-1:0]           x_repeat;
    logic [OP_W-1:0]           y_repeat;
    logic signed [SCORE_W-1:0] mul_a;
    logic [OP_W-1:0]           mul_op;
    logic [CHUNK_W-1:0]        mul_chunk;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   term;
    logic signed [ACC_W-1:0]   acc_next;
    logic                      ge;

    assign sum_ready = state_reg == S_IDLE;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Total matches and the six two-class sums
    assign m_sum = (CNT_W+2)'(sum_reg.match[0]) + (CNT_W+2)'(sum_reg.match[1]) +
                   (CNT_W+2)'(sum_reg.match[2]) + (CNT_W+2)'(sum_reg.match[3]);
    assign pair_sum[0] = sum_reg.match[0] + sum_reg.match[1];
    assign pair_sum[1] = sum_reg.match[0] + sum_reg.match[2];
    assign pair_sum[2] = sum_reg.match[0] + sum_reg.match[3];
    assign pair_sum[3] = sum_reg.match[1] + sum_reg.match[2];
    assign pair_sum[4] = sum_reg.match[1] + sum_reg.match[3];
    assign pair_sum[5] = sum_reg.match[2] + sum_reg.match[3];

    // Pick the best two-class sum
    always_comb begin
        best_max = pair_sum_reg[0];
        for (int k = 1; k < 6; k++) begin
            if (pair_sum_reg[k] > best_max) begin
                best_max = pair_sum_reg[k];
            end
        end
    end

    // Degeneracy operands: 5B > 4M, then S*(501M - 500B) against min*100M
    assign m_ext     = EXT_W'(m_reg);
    assign b_ext     = EXT_W'(best_reg);
    assign degen_bad = ((b_ext << 2) + b_ext) > (m_ext << 2);
    assign x_degen   = (m_ext << 9) - (m_ext << 3) - (m_ext << 1) - m_ext -
                       ((b_ext << 9) - (b_ext << 3) - (b_ext << 2));
    assign y_degen   = (m_ext << 6) + (m_ext << 5) + (m_ext << 2);

    // Repeat operands: S*2*(T - R) against min*T
    assign unmasked = sum_reg.pairs - sum_reg.repeats;
    assign x_repeat = {{(OP_W-CNT_W-1){1'b0}}, unmasked, 1'b0};
    assign y_repeat = OP_W'(sum_reg.pairs);

    // One partial product per step: a*xl, a*xh, b*yl, b*yh
    assign mul_a     = step_reg[1] ? min_score : sum_reg.score;
    assign mul_op    = step_reg[1] ? op_y_reg : op_x_reg;
    assign mul_chunk = step_reg[0] ? mul_op[OP_W-1:CHUNK_W] : mul_op[CHUNK_W-1:0];
    assign prod_next = mul_a * $signed({1'b0, mul_chunk});

    // Accumulate the previous partial product
    always_comb begin
        term = ACC_W'(prod_reg);
        if (prod_shift_reg) begin
            term = term <<< CHUNK_W;
        end
        acc_next = prod_neg_reg ? (acc_reg - term) : (acc_reg + term);
    end

    assign ge = !acc_reg[ACC_W-1];

    // Decision sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= 3'd0;
            cmp_sel_reg   <= CMP_DEGEN;
            pass_reg      <= 1'b0;
        end else begin
            // Drop a taken verdict unless a new one replaces it
            if (out_valid_reg && m_tready && state_reg != S_DONE) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (sum_valid) begin
                        sum_reg   <= sum_data;
                        state_reg <= S_SUM;
                    end
                end
                S_SUM: begin
                    m_reg        <= m_sum[CNT_W-1:0];
                    pair_sum_reg <= pair_sum;
                    state_reg    <= S_BEST;
                end
                S_BEST: begin
                    best_reg  <= best_max;
                    state_reg <= S_PREP;
                end
                S_PREP: begin
                    step_reg <= 3'd0;
                    acc_reg  <= '0;
                    if (sum_reg.ovf) begin
                        pass_reg  <= 1'b0;
                        state_reg <= S_DONE;
                    end else if (sum_reg.score >= no_check_score) begin
                        pass_reg  <= 1'b1;
                        state_reg <= S_DONE;
                    end else if (m_reg == '0) begin
                        pass_reg  <= 1'b0;
                        state_reg <= S_DONE;
                    end else if (degen_bad) begin
                        op_x_reg    <= x_degen[OP_W-1:0];
                        op_y_reg    <= y_degen[OP_W-1:0];
                        cmp_sel_reg <= CMP_DEGEN;
                        state_reg   <= S_MUL;
                    end else begin
                        op_x_reg    <= x_repeat;
                        op_y_reg    <= y_repeat;
                        cmp_sel_reg <= CMP_REPEAT;
                        state_reg   <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (step_reg != LAST_STEP) begin
                        prod_reg       <= prod_next;
                        prod_shift_reg <= step_reg[0];
                        prod_neg_reg   <= step_reg[1];
                    end
                    if (step_reg != 3'd0) begin
                        acc_reg <= acc_next;
                    end
                    if (step_reg == LAST_STEP) begin
                        state_reg <= S_EVAL;
                    end else begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                S_EVAL: begin
                    if (cmp_sel_reg == CMP_DEGEN && ge) begin
                        op_x_reg    <= x_repeat;
                        op_y_reg    <= y_repeat;
                        cmp_sel_reg <= CMP_REPEAT;
                        step_reg    <= 3'd0;
                        acc_reg     <= '0;
                        state_reg   <= S_MUL;
                    end else begin
                        pass_reg  <= ge;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {4'b0000, sum_reg.ovf, sum_reg.repeats,
                                          m_reg, pass_reg};
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/chain_repeat_degeneracy_filter_top.sv */
// Chain repeat and degeneracy filter. Stream the aligned base pairs of a chain, one
// pair per item, with tlast on the final pair; one verdict item comes out per chain.
// Pairs are counted at one per clock while the queue has room. The final pair hands
// the chain totals to a two-entry queue; a decision sequencer then loads them, sums
// the matches, picks the best two-class sum and settles the chain by overflow, the
// no-check score or zero matches, or else by one or two exact product comparisons,
// each built from the four partial products of its shared 32x18 multiplier; a
// stalled verdict adds its wait. Chains that arrive faster than the sequencer settles
// them back up the queue and the pair input stalls until it drains. Registers: 0x0
// min_score, 0x4 no_check_score; write only while no chain is in flight.
module chain_repeat_degeneracy_filter_top import crdf_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // target_base[7:0], query_base[15:8], chain_score[47:16]
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    // pass[0], match_total[29:1], repeat_total[58:30], overflow[59], zero[63:60]
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic REG_MIN_SCORE = 1'b0;
    localparam logic REG_NO_CHECK  = 1'b1;

    logic signed [SCORE_W-1:0] min_score_reg;
    logic signed [SCORE_W-1:0] no_check_reg;
    logic                      cfg_write;

    summary_t front_data;
    logic     front_valid;
    logic     front_ready;
    summary_t back_data;
    logic     back_valid;
    logic     back_ready;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_NO_CHECK) ? no_check_reg : min_score_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_score_reg <= 32'sd5000;
            no_check_reg  <= 32'sd200000;
        end else if (cfg_write) begin
            if (paddr[2] == REG_MIN_SCORE) begin
                min_score_reg <= pwdata;
            end else begin
                no_check_reg <= pwdata;
            end
        end
    end

    crdf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .sum_data  (front_data),
        .sum_valid (front_valid),
        .sum_ready (front_ready)
    );

    crdf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (front_data),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_data  (back_data),
        .out_valid (back_valid),
        .out_ready (back_ready)
    );

    crdf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .sum_data       (back_data),
        .sum_valid      (back_valid),
        .sum_ready      (back_ready),
        .min_score      (min_score_reg),
        .no_check_score (no_check_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule

/* hdl/crdf_checker.sv */
module crdf_assertions import crdf_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // No verdict right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("verdict valid after reset");

    // Hold a stalled verdict
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled verdict changed");

    // An overflowed chain never passes
    a_ovf_fails: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[59] && m_tdata[0]))
        else $error("overflowed chain passed");

    // Totals stay within the pair bound and padding stays zero
    a_totals: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[29:1] <= MAX_CHAIN_PAIRS) &&
                     (m_tdata[58:30] <= MAX_CHAIN_PAIRS) && (m_tdata[63:60] == 4'b0000))
        else $error("verdict totals out of range");

endmodule

bind chain_repeat_degeneracy_filter_top crdf_assertions u_crdf_assertions (.*);
